### src/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8sd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 21;
	localparam int unsigned MAX_RES = 4;
	localparam int unsigned CNT_W  = 3;

	localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

	localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
	localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;
	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
	localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;
	localparam logic [BYTE_W-1:0] PAYLOAD_MASK = 8'h3F;

	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic            rep;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0]         cnt;
		result_t [MAX_RES-1:0]    res;
	} result_list_t;

endpackage

`default_nettype wire

### src/u8sd_decode.sv
// ----------------------------------------------------------------------------
// u8sd_decode
// Sequence state and per-byte decode into a list of up to four results.
// ----------------------------------------------------------------------------
`default_nettype none

module u8sd_decode import u8sd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic [BYTE_W-1:0] byte_s1,
	input  wire logic              eos_s1,
	output result_list_t           list
);

	typedef enum logic [2:0] {
		LEAD_ASCII,
		LEAD_TWO,
		LEAD_THREE,
		LEAD_FOUR,
		LEAD_BAD
	} lead_t;

	logic [CP_W-1:0] acc_q, acc_n;
	logic [1:0]      pend_q, pend_n;
	logic [1:0]      good_q, good_n;

	lead_t kind;

	always_comb begin
		if (!byte_s1[BYTE_W-1])
			kind = LEAD_ASCII;
		else if ((byte_s1 & LEAD2_MASK) == LEAD2_CODE)
			kind = LEAD_TWO;
		else if ((byte_s1 & LEAD3_MASK) == LEAD3_CODE)
			kind = LEAD_THREE;
		else if ((byte_s1 & LEAD4_MASK) == LEAD4_CODE)
			kind = LEAD_FOUR;
		else
			kind = LEAD_BAD;
	end

	always_comb begin
		logic            is_cont;
		logic [CNT_W-1:0] reps;
		logic [CNT_W-1:0] n;
		is_cont = (byte_s1 & CONT_MASK) == CONT_CODE;
		acc_n  = acc_q;
		pend_n = pend_q;
		good_n = good_q;
		n      = '0;
		reps   = '0;
		for (int k = 0; k < MAX_RES; k++) begin
			list.res[k].cp  = REPL_CP;
			list.res[k].rep = 1'b1;
		end

		if (pend_q != 2'd0 && is_cont) begin
			// extend the open sequence by six bits
			acc_n  = {acc_q[CP_W-7:0], byte_s1[5:0]};
			pend_n = pend_q - 2'd1;
			good_n = good_q + 2'd1;
			if (pend_n == 2'd0) begin
				list.res[0].cp  = acc_n;
				list.res[0].rep = 1'b0;
				n      = 3'd1;
				good_n = 2'd0;
			end
		end else begin
			// broken sequence: one replacement for the lead and each good continuation
			if (pend_q != 2'd0)
				reps = (good_q == 2'd3) ? 3'd3 : 3'd1 + {1'b0, good_q};
			else
				reps = 3'd0;
			n      = reps;
			pend_n = 2'd0;
			good_n = 2'd0;
			unique case (kind)
				LEAD_ASCII: begin
					list.res[reps[1:0]].cp  = {{(CP_W-BYTE_W){1'b0}}, byte_s1};
					list.res[reps[1:0]].rep = 1'b0;
					n = reps + 3'd1;
				end
				LEAD_TWO: begin
					acc_n  = {{(CP_W-5){1'b0}}, byte_s1[4:0]};
					pend_n = 2'd1;
				end
				LEAD_THREE: begin
					acc_n  = {{(CP_W-4){1'b0}}, byte_s1[3:0]};
					pend_n = 2'd2;
				end
				LEAD_FOUR: begin
					acc_n  = {{(CP_W-3){1'b0}}, byte_s1[2:0]};
					pend_n = 2'd3;
				end
				default: begin
					n = reps + 3'd1;
				end
			endcase
		end

		// close a sequence left open at end of stream
		if (eos_s1 && pend_n != 2'd0) begin
			n      = n + 3'd1;
			pend_n = 2'd0;
			good_n = 2'd0;
			acc_n  = '0;
		end
		list.cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pend_q <= '0;
			good_q <= '0;
		end else if (fire) begin
			acc_q  <= acc_n;
			pend_q <= pend_n;
			good_q <= good_n;
		end
	end

	a_eos_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && eos_s1) |=> (pend_q == 2'd0))
		else $error("sequence still open after end of stream");

	a_good_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(good_q != 2'd3) && (pend_q != 2'd0 || good_q == 2'd0))
		else $error("continuation count out of step with pending count");

	a_list_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (list.cnt <= CNT_W'(MAX_RES)))
		else $error("more results than the buffer holds");

endmodule

`default_nettype wire

### src/u8sd_result_buf.sv
// ----------------------------------------------------------------------------
// u8sd_result_buf
// Registered result list, drained one result per output request.
// ----------------------------------------------------------------------------
`default_nettype none

module u8sd_result_buf import u8sd_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load_req,
	input  wire result_list_t    list,
	output logic                 can_load,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [CP_W-1:0]      code_point,
	output logic                 replaced,
	output logic                 run_last
);

	result_t [MAX_RES-1:0] ent_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  take;
	logic                  load;

	assign take     = (cnt_q != '0) && !out_stall;
	assign can_load = (cnt_q == '0) || (cnt_q == 3'd1 && take);
	assign load     = load_req && can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= list.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= list.res;
		end else if (take) begin
			// advance the list toward the head
			for (int k = 0; k < MAX_RES - 1; k++)
				ent_q[k] <= ent_q[k+1];
		end
	end

	assign out_valid  = cnt_q != '0;
	assign code_point = ent_q[0].cp;
	assign replaced   = ent_q[0].rep;
	assign run_last   = cnt_q == 3'd1;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RES))
		else $error("result count overflow");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cnt_q > 3'd1) |=> (cnt_q == $past(cnt_q) - 3'd1))
		else $error("result lost or repeated while draining");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q > 3'd1) |-> !can_load)
		else $error("load while results still queued");

endmodule

`default_nettype wire

### src/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Decodes a UTF-8 byte stream into 21-bit code points with replacement marks.
// ----------------------------------------------------------------------------
//   channel | direction | handshake             | payload
//   input   | in        | in_valid / in_stall   | in_byte[7:0], end_of_stream
//   output  | out       | out_valid / out_stall | code_point[20:0], replaced, run_last
//
// A byte enters an input register, is decoded combinationally and its results
// (zero to four) are loaded into the result register.
// Results leave one per cycle while out_stall is low; a byte with one result
// sustains one byte per cycle, a byte with more results holds the input until all but its last result have left.
// A byte with no result loads an empty list into the result register.
// Reset clears the sequence state and both registers' valid flags.
// out_stall backs up into in_stall only when the result register cannot take
// the waiting byte's list.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder import u8sd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [BYTE_W-1:0] in_byte,
	input  wire logic              end_of_stream,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [CP_W-1:0]        code_point,
	output logic                   replaced,
	output logic                   run_last
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              eos_s1;
	logic              can_load;
	logic              fire;
	logic              accept;
	result_list_t      list;

	assign fire     = valid_s1 && can_load;
	assign in_stall = valid_s1 && !can_load;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
			eos_s1  <= end_of_stream;
		end
	end

	u8sd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_s1 (byte_s1),
		.eos_s1  (eos_s1),
		.list    (list)
	);

	u8sd_result_buf u_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_req   (valid_s1),
		.list       (list),
		.can_load   (can_load),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_point (code_point),
		.replaced   (replaced),
		.run_last   (run_last)
	);

endmodule

`default_nettype wire
